/* sv/tga_rle_pkg.sv */
// Shared types and constants of the TGA run-length pixel decoder.
`default_nettype none

package tga_rle_pkg;

	// Configuration register file.
	localparam int CFG_INDEX_W = 1;
	localparam int CFG_DATA_W  = 32;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_BYTES_PER_PIXEL = 1'b0,
		REG_PIXEL_COUNT     = 1'b1
	} cfg_reg_t;

	localparam logic [2:0]  BPP_RESET         = 3'd4;
	localparam logic [31:0] PIXEL_COUNT_RESET = 32'd1;

	// Longest packet a header can open.
	localparam logic [7:0] MAX_PACKET_PIXELS = 8'd128;

	// Entries in the queue between the parser and the result port.
	localparam int QUEUE_DEPTH = 2;

	// One decoded word as it leaves the block.
	typedef struct packed {
		logic [31:0] pixel_value;
		logic [7:0]  repeat_count;
		logic        image_done;
		logic        overrun_error;
	} result_t;

endpackage

`default_nettype wire

/* sv/tga_rle_front.sv */
// Front end: packet header parsing, pixel assembly and image pixel accounting.
`default_nettype none

module tga_rle_front (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 accept,
	input  logic [7:0]                           data_byte,
	input  logic                                 cfg_we,
	input  logic [tga_rle_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  logic [tga_rle_pkg::CFG_DATA_W-1:0]   cfg_wdata,
	output logic                                 tok_valid,
	output tga_rle_pkg::result_t                 tok
);
	import tga_rle_pkg::*;

	logic [2:0]  bpp_q;
	logic [31:0] pixel_count_q;
	logic        expect_header_q;
	logic        packet_is_run_q;
	logic [7:0]  left_q;
	logic [1:0]  byte_idx_q;
	logic [23:0] partial_q;
	logic [31:0] pixels_done_q;
	logic [31:0] remaining_q;

	logic [2:0]  pix_size;
	logic        last_byte;
	logic [31:0] value;
	logic        pixel_end;
	logic        run_fits;
	logic        run_exact;
	logic        rem_nonzero;
	logic        rem_one;
	logic [7:0]  left_dec;
	logic [7:0]  repeat_cnt;
	logic        done;
	logic        overrun;
	logic        image_clear;
	logic [7:0]  consumed;

	// Pixel size: zero acts as one byte, anything above four as four.
	always_comb begin
		priority if (bpp_q == 3'd0) begin
			pix_size = 3'd1;
		end else if (bpp_q > 3'd4) begin
			pix_size = 3'd4;
		end else begin
			pix_size = bpp_q;
		end
	end

	assign last_byte = (({1'b0, byte_idx_q}) + 3'd1) >= pix_size;
	assign value     = {8'd0, partial_q} | ({24'd0, data_byte} << {byte_idx_q, 3'b000});
	assign pixel_end = accept && !expect_header_q && last_byte;

	// Compare the packet against the pixels still open in the image.
	assign run_fits    = remaining_q >= {24'd0, left_q};
	assign run_exact   = remaining_q == {24'd0, left_q};
	assign rem_nonzero = remaining_q != 32'd0;
	assign rem_one     = remaining_q == 32'd1;
	assign left_dec    = (left_q != 8'd0) ? left_q - 8'd1 : 8'd0;

	// Classify the finished pixel.
	always_comb begin
		if (packet_is_run_q) begin
			repeat_cnt = run_fits ? left_q : remaining_q[7:0];
			done       = run_fits ? run_exact : 1'b1;
			overrun    = !run_fits;
			consumed   = left_q;
		end else begin
			repeat_cnt = rem_nonzero ? 8'd1 : 8'd0;
			done       = rem_nonzero ? rem_one : 1'b1;
			overrun    = !rem_nonzero;
			consumed   = 8'd1;
		end
		// The image restarts when a full image ends with its packet, or on any overrun.
		image_clear = done && (packet_is_run_q || !rem_nonzero || (left_dec == 8'd0));
	end

	assign tok_valid         = pixel_end;
	assign tok.pixel_value   = value;
	assign tok.repeat_count  = repeat_cnt;
	assign tok.image_done    = done;
	assign tok.overrun_error = overrun;

	// Configuration registers and parser state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bpp_q           <= BPP_RESET;
			pixel_count_q   <= PIXEL_COUNT_RESET;
			expect_header_q <= 1'b1;
			packet_is_run_q <= 1'b0;
			left_q          <= 8'd0;
			byte_idx_q      <= 2'd0;
			partial_q       <= 24'd0;
			pixels_done_q   <= 32'd0;
			remaining_q     <= PIXEL_COUNT_RESET;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_BYTES_PER_PIXEL: begin
					bpp_q <= cfg_wdata[2:0];
				end
				REG_PIXEL_COUNT: begin
					pixel_count_q <= cfg_wdata;
					remaining_q   <= (cfg_wdata > pixels_done_q) ?
						cfg_wdata - pixels_done_q : 32'd0;
				end
				default: begin
				end
			endcase
		end else if (accept) begin
			if (expect_header_q) begin
				// Header: bit 7 picks run or raw, low bits give length minus one.
				packet_is_run_q <= data_byte[7];
				left_q          <= {1'b0, data_byte[6:0]} + 8'd1;
				expect_header_q <= 1'b0;
				byte_idx_q      <= 2'd0;
				partial_q       <= 24'd0;
			end else if (!last_byte) begin
				partial_q  <= value[23:0];
				byte_idx_q <= byte_idx_q + 2'd1;
			end else begin
				byte_idx_q <= 2'd0;
				partial_q  <= 24'd0;
				if (image_clear) begin
					expect_header_q <= 1'b1;
					left_q          <= 8'd0;
					pixels_done_q   <= 32'd0;
					remaining_q     <= pixel_count_q;
				end else begin
					pixels_done_q <= pixels_done_q + {24'd0, consumed};
					remaining_q   <= remaining_q - {24'd0, consumed};
					if (packet_is_run_q || (left_dec == 8'd0)) begin
						expect_header_q <= 1'b1;
						left_q          <= 8'd0;
					end else begin
						left_q <= left_dec;
					end
				end
			end
		end
	end

endmodule

`default_nettype wire

/* sv/tga_rle_queue.sv */
// Back end: short queue of decoded words that drives the result port.
`default_nettype none

module tga_rle_queue #(
	parameter int DEPTH = tga_rle_pkg::QUEUE_DEPTH
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 wr_en,
	input  tga_rle_pkg::result_t wr_data,
	output logic                 full,
	input  logic                 rd_en,
	output logic                 empty,
	output tga_rle_pkg::result_t rd_data
);
	import tga_rle_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	result_t            mem_q [DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]   count_q;
	logic               do_wr;
	logic               do_rd;

	assign full    = count_q == CNT_W'(DEPTH);
	assign empty   = count_q == '0;
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	// Word storage.
	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	// Pointers wrap at the depth; the count tracks occupancy.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + CNT_W'(1);
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

endmodule

`default_nettype wire

/* sv/tga_rle_pixel_decoder.sv */
// Top level of the TGA run-length pixel decoder.
//
//   Channel  | Handshake        | Word
//   ---------+------------------+---------------------------------------------
//   input    | push / full      | data_byte
//   result   | pop / empty      | pixel_value, repeat_count, image_done,
//            |                  | overrun_error
//   config   | cfg_we           | cfg_index, cfg_wdata
//
// One byte is taken per cycle while full is low; a byte that completes a pixel writes its word
// into the queue in the same cycle, and the result port shows the word at the head of the queue.
// The queue holds QUEUE_DEPTH words; full rises only when it is filled and pop is low.
// Reset sets four bytes per pixel, an image of one pixel, and awaits a packet header.
`default_nettype none

module tga_rle_pixel_decoder #(
	parameter int QUEUE_DEPTH = tga_rle_pkg::QUEUE_DEPTH
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                push,
	output logic                                full,
	input  logic [7:0]                          data_byte,
	output logic                                empty,
	input  logic                                pop,
	output logic [31:0]                         pixel_value,
	output logic [7:0]                          repeat_count,
	output logic                                image_done,
	output logic                                overrun_error,
	input  logic                                cfg_we,
	input  logic [tga_rle_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [tga_rle_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
	import tga_rle_pkg::*;

	logic    accept;
	logic    tok_valid;
	result_t tok;
	result_t head;

	assign accept = push && !full;

	// Parser and pixel accounting.
	tga_rle_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.data_byte (data_byte),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.tok_valid (tok_valid),
		.tok       (tok)
	);

	// Result queue.
	tga_rle_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (tok_valid),
		.wr_data (tok),
		.full    (full),
		.rd_en   (pop),
		.empty   (empty),
		.rd_data (head)
	);

	assign pixel_value   = head.pixel_value;
	assign repeat_count  = head.repeat_count;
	assign image_done    = head.image_done;
	assign overrun_error = head.overrun_error;

	// A decoded word only comes from an accepted byte.
	a_word_from_byte: assert property (@(posedge clk) disable iff (!arst_n)
		tok_valid |-> accept)
		else $error("decoded word without an accepted byte");

	// An overrun always ends the image.
	a_overrun_ends_image: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && overrun_error) |-> image_done)
		else $error("overrun word not marked as image end");

	// A zero repeat count only appears on an overrun.
	a_zero_repeat_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && (repeat_count == 8'd0)) |-> overrun_error)
		else $error("zero repeat count without overrun");

	// Repeat count never exceeds the longest packet.
	a_repeat_bound: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (repeat_count <= MAX_PACKET_PIXELS))
		else $error("repeat count beyond packet length");

endmodule

`default_nettype wire

/* dv/tga_rle_pixel_decoder_test.sv */
// Self-checking testbench of the TGA run-length pixel decoder: directed table, then random packets.
`default_nettype none

module tga_rle_pixel_decoder_test;
	import tga_rle_pkg::*;

	localparam int ITEM_TARGET   = 600;
	localparam int SETTLE_CYCLES = 4;
	localparam int DRAIN_CYCLES  = 10;
	localparam int STALL_LIMIT   = 2000;

	typedef enum logic {
		ROW_BYTE,
		ROW_CFG
	} row_kind_t;

	// One row of the directed table: a stream byte or a register write.
	typedef struct {
		row_kind_t   kind;
		cfg_reg_t    idx;
		logic [31:0] val;
		bit          typed;
		result_t     want;
	} step_t;

	localparam result_t NO_WORD = '0;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        push;
	logic        full;
	logic [7:0]  data_byte;
	logic        empty;
	logic        pop = 1'b0;
	logic [31:0] pixel_value;
	logic [7:0]  repeat_count;
	logic        image_done;
	logic        overrun_error;
	logic        cfg_we;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0]  cfg_wdata;

	// Expected word given with the byte, used instead of the predicted one.
	bit      typed_on;
	result_t typed_word;

	// Predictor state and its copy of the registers.
	logic [2:0]  cfg_bpp;
	logic [31:0] cfg_count;
	bit          hdr_wait;
	bit          run_pkt;
	logic [7:0]  pkt_left;
	logic [1:0]  byte_idx;
	logic [23:0] partial_px;
	logic [31:0] px_done;

	result_t pending_words[$];
	int      mismatches  = 0;
	int      items_sent  = 0;
	int      idle_cycles = 0;
	bit      send_calm   = 1'b0;
	bit      pop_calm    = 1'b0;
	int      pop_wait    = 0;

	// Directed stimulus: reset defaults, long runs, surplus raw pixels, lowered and zero
	// pixel counts, and the odd pixel sizes.
	step_t plan [30] = '{
		'{ROW_BYTE, REG_BYTES_PER_PIXEL, 32'h80, 1'b0, NO_WORD},
		'{ROW_BYTE, REG_BYTES_PER_PIXEL, 32'h11, 1'b0, NO_WORD},
		'{ROW_BYTE, REG_BYTES_PER_PIXEL, 32'h22, 1'b0, NO_WORD},
		'{ROW_BYTE, REG_BYTES_PER_PIXEL, 32'h33, 1'b0, NO_WORD},
		'{ROW_BYTE, REG_BYTES_PER_PIXEL, 32'h44, 1'b1, result_t'{32'h44332211, 8'd1, 1'b1, 1'b0}},
		'{ROW_CFG,  REG_BYTES_PER_PIXEL, 32'd1,  1'b0, NO_WORD},
		'{ROW_CFG,  REG_PIXEL_COUNT,     32'd3,  1'b0, NO_WORD},
		'{ROW_BYTE, REG_BYTES_PER_PIXEL, 32'hFF, 1'b0, NO_WORD},
		'{ROW_BYTE, REG_BYTES_PER_PIXEL, 32'hFF, 1'b1, result_t'{32'hFF, 8'd3, 1'b1, 1'b1}},
		'{ROW_BYTE, REG_BYTES_PER_PIXEL, 32'h7F, 1'b0, NO_WORD},
		'{ROW_BYTE, REG_BYTES_PER_PIXEL, 32'h00, 1'b0, NO_WORD},
		'{ROW_BYTE, REG_BYTES_PER_PIXEL, 32'h01, 1'b0, NO_WORD},
		'{ROW_BYTE, REG_BYTES_PER_PIXEL, 32'h02, 1'b1, result_t'{32'h02, 8'd1, 1'b1, 1'b0}},
		'{ROW_BYTE, REG_BYTES_PER_PIXEL, 32'h03, 1'b1, result_t'{32'h03, 8'd0, 1'b1, 1'b1}},
		'{ROW_BYTE, REG_BYTES_PER_PIXEL, 32'h01, 1'b0, NO_WORD},
		'{ROW_BYTE, REG_BYTES_PER_PIXEL, 32'h05, 1'b0, NO_WORD},
		'{ROW_CFG,  REG_PIXEL_COUNT,     32'd0,  1'b0, NO_WORD},
		'{ROW_BYTE, REG_BYTES_PER_PIXEL, 32'h06, 1'b1, result_t'{32'h06, 8'd0, 1'b1, 1'b1}},
		'{ROW_BYTE, REG_BYTES_PER_PIXEL, 32'h85, 1'b0, NO_WORD},
		'{ROW_BYTE, REG_BYTES_PER_PIXEL, 32'hAA, 1'b1, result_t'{32'hAA, 8'd0, 1'b1, 1'b1}},
		'{ROW_CFG,  REG_PIXEL_COUNT,     32'd2,  1'b0, NO_WORD},
		'{ROW_CFG,  REG_BYTES_PER_PIXEL, 32'd0,  1'b0, NO_WORD},
		'{ROW_BYTE, REG_BYTES_PER_PIXEL, 32'h80, 1'b0, NO_WORD},
		'{ROW_BYTE, REG_BYTES_PER_PIXEL, 32'h5A, 1'b0, NO_WORD},
		'{ROW_CFG,  REG_BYTES_PER_PIXEL, 32'd7,  1'b0, NO_WORD},
		'{ROW_BYTE, REG_BYTES_PER_PIXEL, 32'h00, 1'b0, NO_WORD},
		'{ROW_BYTE, REG_BYTES_PER_PIXEL, 32'hDE, 1'b0, NO_WORD},
		'{ROW_BYTE, REG_BYTES_PER_PIXEL, 32'hAD, 1'b0, NO_WORD},
		'{ROW_BYTE, REG_BYTES_PER_PIXEL, 32'hBE, 1'b0, NO_WORD},
		'{ROW_BYTE, REG_BYTES_PER_PIXEL, 32'hEF, 1'b1, result_t'{32'hEFBEADDE, 8'd1, 1'b1, 1'b0}}
	};

	tga_rle_pixel_decoder u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.push          (push),
		.full          (full),
		.data_byte     (data_byte),
		.empty         (empty),
		.pop           (pop),
		.pixel_value   (pixel_value),
		.repeat_count  (repeat_count),
		.image_done    (image_done),
		.overrun_error (overrun_error),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_wdata     (cfg_wdata)
	);

	always #5 clk = ~clk;

	// Register values 0 and 5 to 7 fall back to the nearest legal pixel size.
	function automatic int pixel_bytes(logic [2:0] bpp);
		if (bpp == 3'd0) return 1;
		if (bpp > 3'd4) return 4;
		return int'(bpp);
	endfunction

	// Mostly no gap, some short ones and a few long ones.
	function automatic int pick_gap(bit calm);
		int r;
		if (calm) return 0;
		r = $urandom_range(0, 99);
		if (r < 65) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic logic [31:0] pick_count();
		case ($urandom_range(0, 15))
			0: return 32'd0;
			1: return 32'hFFFF_FFFF;
			2: return 32'd4294836225;
			3: return 32'($urandom_range(50, 300));
			default: return 32'($urandom_range(1, 24));
		endcase
	endfunction

	// Clear the image counters so the next byte opens a new image.
	function automatic void clear_image();
		hdr_wait   = 1'b1;
		pkt_left   = 8'd0;
		byte_idx   = 2'd0;
		partial_px = 24'd0;
		px_done    = 32'd0;
	endfunction

	// Advance the decoder state by one stream byte; returns 1 with the word it emits.
	function automatic bit decode_byte(logic [7:0] b, output result_t word);
		logic [31:0] value;
		logic [31:0] remaining;
		logic [7:0]  rep;
		bit          img_end;
		bit          over;
		word    = '0;
		rep     = 8'd0;
		img_end = 1'b0;
		over    = 1'b0;
		if (hdr_wait) begin
			run_pkt    = b[7];
			pkt_left   = b[7] ? 8'(b - 8'd127) : 8'(b + 8'd1);
			hdr_wait   = 1'b0;
			byte_idx   = 2'd0;
			partial_px = 24'd0;
			return 1'b0;
		end
		value = {8'h00, partial_px} | (32'(b) << (8 * byte_idx));
		if (int'(byte_idx) + 1 < pixel_bytes(cfg_bpp)) begin
			partial_px = value[23:0];
			byte_idx   = byte_idx + 2'd1;
			return 1'b0;
		end
		byte_idx   = 2'd0;
		partial_px = 24'd0;
		remaining  = (px_done < cfg_count) ? cfg_count - px_done : 32'd0;
		if (run_pkt) begin
			// A run is clipped to what is left of the image.
			if (32'(pkt_left) <= remaining) begin
				rep     = pkt_left;
				px_done = px_done + 32'(pkt_left);
				img_end = (px_done == cfg_count);
			end else begin
				rep     = remaining[7:0];
				over    = 1'b1;
				img_end = 1'b1;
			end
			pkt_left = 8'd0;
			hdr_wait = 1'b1;
			if (img_end) clear_image();
		end else if (remaining != 32'd0) begin
			rep     = 8'd1;
			px_done = px_done + 32'd1;
			img_end = (px_done == cfg_count);
			if (pkt_left != 8'd0) pkt_left = pkt_left - 8'd1;
			if (pkt_left == 8'd0) begin
				hdr_wait = 1'b1;
				if (img_end) clear_image();
			end
		end else begin
			// Raw pixel past the end of the image: dropped with repeat zero.
			over    = 1'b1;
			img_end = 1'b1;
			clear_image();
		end
		word.pixel_value   = value;
		word.repeat_count  = rep;
		word.image_done    = img_end;
		word.overrun_error = over;
		return 1'b1;
	endfunction

	task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
		if (got !== want) begin
			$display("%0t: %s expected %0h, got %0h", $time, name, want, got);
			mismatches++;
		end
	endtask

	// Offer one byte and hold it until the block takes it.
	task automatic send_byte(logic [7:0] b, bit typed, result_t word);
		int gap;
		gap = pick_gap(send_calm);
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		push       <= 1'b1;
		data_byte  <= b;
		typed_on   <= typed;
		typed_word <= word;
		do @(posedge clk); while (full);
		items_sent++;
	endtask

	// Write a register once every expected word has come out.
	task automatic write_reg(cfg_reg_t idx, logic [31:0] val);
		push <= 1'b0;
		@(posedge clk);
		while (pending_words.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// One setting of the registers followed by a burst of packets, mostly well formed.
	task automatic random_phase(int stop_at);
		logic [2:0] bpp;
		int         size;
		int         len;
		int         nbytes;
		int         kind;
		bit         run;
		bpp       = 3'($urandom_range(0, 7));
		size      = pixel_bytes(bpp);
		send_calm = ($urandom_range(0, 3) == 0);
		write_reg(REG_BYTES_PER_PIXEL, 32'(bpp));
		write_reg(REG_PIXEL_COUNT, pick_count());
		repeat ($urandom_range(4, 12)) begin
			kind   = $urandom_range(0, 9);
			len    = ($urandom_range(0, 24) == 0) ? $urandom_range(1, 128) : $urandom_range(1, 6);
			run    = $urandom_range(0, 1);
			nbytes = run ? size : size * len;
			if (kind == 0) begin
				// Stray bytes with no header of their own.
				nbytes = $urandom_range(1, 6);
			end else begin
				send_byte(run ? 8'(127 + len) : 8'(len - 1), 1'b0, NO_WORD);
				// A cut packet: the next header lands inside the packet.
				if (kind == 1) nbytes = $urandom_range(0, nbytes - 1);
			end
			repeat (nbytes) send_byte(8'($urandom_range(0, 255)), 1'b0, NO_WORD);
			if (items_sent >= stop_at) break;
		end
	endtask

	// Result side: pop with random stalls, with calm stretches now and then.
	always @(posedge clk) begin
		if ($urandom_range(0, 299) == 0) pop_calm <= !pop_calm;
		if (pop_wait > 0) begin
			pop      <= 1'b0;
			pop_wait <= pop_wait - 1;
		end else begin
			pop      <= 1'b1;
			pop_wait <= pick_gap(pop_calm);
		end
	end

	// Check each popped word, predict each accepted byte, track register writes and stalls.
	always @(posedge clk) begin : monitor
		result_t want_w;
		result_t pred_w;
		bit      moved;
		if (arst_n) begin
			moved = 1'b0;
			if (pop && !empty) begin
				moved = 1'b1;
				if (pending_words.size() == 0) begin
					$display("%0t: no word expected, got pixel_value %0h repeat_count %0d",
						$time, pixel_value, repeat_count);
					mismatches++;
				end else begin
					want_w = pending_words.pop_front();
					check_field("pixel_value", want_w.pixel_value, pixel_value);
					check_field("repeat_count", 32'(want_w.repeat_count), 32'(repeat_count));
					check_field("image_done", 32'(want_w.image_done), 32'(image_done));
					check_field("overrun_error", 32'(want_w.overrun_error), 32'(overrun_error));
				end
			end
			if (push && !full) begin
				moved = 1'b1;
				if (decode_byte(data_byte, pred_w))
					pending_words.push_back(typed_on ? typed_word : pred_w);
			end
			if (cfg_we) begin
				moved = 1'b1;
				case (cfg_index)
					REG_BYTES_PER_PIXEL: cfg_bpp = cfg_wdata[2:0];
					REG_PIXEL_COUNT:     cfg_count = cfg_wdata;
					default: ;
				endcase
			end
			idle_cycles = moved ? 0 : idle_cycles + 1;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("%0t: no word moved for %0d cycles", $time, STALL_LIMIT);
				$display("tga_rle_pixel_decoder test failed");
				$finish;
			end
		end
	end

	// Main sequence: reset, directed table, random phases, drain.
	initial begin
		int stop_at;
		arst_n     = 1'b0;
		push       = 1'b0;
		data_byte  = 8'd0;
		cfg_we     = 1'b0;
		cfg_index  = REG_BYTES_PER_PIXEL;
		cfg_wdata  = '0;
		typed_on   = 1'b0;
		typed_word = NO_WORD;
		cfg_bpp    = BPP_RESET;
		cfg_count  = PIXEL_COUNT_RESET;
		run_pkt    = 1'b0;
		clear_image();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[i]) begin
			if (plan[i].kind == ROW_CFG)
				write_reg(plan[i].idx, plan[i].val);
			else
				send_byte(plan[i].val[7:0], plan[i].typed, plan[i].want);
		end

		stop_at = items_sent + ITEM_TARGET;
		while (items_sent < stop_at) random_phase(stop_at);

		push <= 1'b0;
		@(posedge clk);
		while (pending_words.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("tga_rle_pixel_decoder test passed");
		else
			$display("tga_rle_pixel_decoder test failed");
		$finish;
	end

endmodule

`default_nettype wire
